@@ hw/rtl/spd_pkg.sv @@
// Shared types and constants for the spectrum peak hold and decay block.
// Holds the controller-to-datapath command and status structs.
// No dependencies.
package spd_pkg;

  localparam int unsigned LevelW   = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned GainW    = 16;
  localparam int unsigned FadeW    = 10;
  localparam int unsigned IntensW  = 16;
  localparam int unsigned DenW     = 17;
  localparam int unsigned QuotW    = 15;
  localparam int unsigned StepCntW = 4;
  localparam logic [StepCntW-1:0] LastStep = StepCntW'(QuotW - 1);
  localparam logic [IntensW-1:0] FullScale = 16'h8000;

  localparam logic [2:0] AddrGain = 3'd0;
  localparam logic [2:0] AddrFade = 3'd4;

  typedef struct packed {
    logic accept;    // an item is taken this cycle
    logic prep;      // multiply peak, load divider
    logic div_step;  // one quotient bit
    logic finish;    // update held level and load the output register
  } spd_cmd_t;

  typedef struct packed {
    logic div_last;  // current divider step is the final one
    logic out_full;  // output register holds an item that is stalled
  } spd_status_t;

endpackage

@@ hw/rtl/spd_ctrl.sv @@
// Controller state machine for the peak hold block.
// Depends on spd_pkg for the command and status structs.
module spd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 last_bin,
  output logic                 in_stall,
  output spd_pkg::spd_cmd_t    cmd,
  input  spd_pkg::spd_status_t status
);
  import spd_pkg::*;

  typedef enum logic [1:0] {IDLE, PREP, DIV, FIN} state_t;
  state_t state;

  assign in_stall = (state != IDLE);

  always_comb begin
    cmd          = '0;
    cmd.accept   = in_valid && (state == IDLE);
    cmd.prep     = (state == PREP);
    cmd.div_step = (state == DIV);
    cmd.finish   = (state == FIN) && !status.out_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_valid && last_bin) state <= PREP;
        end
        PREP: state <= DIV;
        DIV: begin
          if (status.div_last) state <= FIN;
        end
        FIN: begin
          if (!status.out_full) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/spd_dpath.sv @@
// Datapath for the peak hold block: running maximum, gain multiply,
// bit-serial decay divider, held level and output register. Depends on spd_pkg.
module spd_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  spd_pkg::spd_cmd_t             cmd,
  output spd_pkg::spd_status_t          status,
  input  logic [spd_pkg::LevelW-1:0]    level,
  input  logic [spd_pkg::TimeW-1:0]     timestamp_ms,
  input  logic                          last_bin,
  input  logic [spd_pkg::GainW-1:0]     gain,
  input  logic [spd_pkg::FadeW-1:0]     fade_tenths,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [spd_pkg::IntensW-1:0]   intensity
);
  import spd_pkg::*;

  logic [LevelW-1:0]          frame_max;
  logic [LevelW-1:0]          peak_max;
  logic [TimeW-1:0]           prev_timestamp;
  logic [TimeW-1:0]           dt;
  logic [DenW-1:0]            den;
  logic [LevelW+GainW-1:0]    product;
  logic                       sat;
  logic [DenW-1:0]            rem;
  logic [QuotW-1:0]           quot;
  logic [StepCntW-1:0]        step_cnt;
  logic [IntensW-1:0]         held_level;

  logic [LevelW-1:0]          folded;
  logic [FadeW-1:0]           fade_eff;
  logic [DenW-1:0]            den_next;
  logic [DenW:0]              rem_sh;
  logic [DenW:0]              rem_diff;
  logic [LevelW+GainW-2:0]    peak_raw;
  logic [IntensW-1:0]         peak;
  logic [IntensW-1:0]         red;
  logic [IntensW-1:0]         decayed;
  logic [IntensW-1:0]         held_next;

  assign folded   = (level > frame_max) ? level : frame_max;
  assign fade_eff = (fade_tenths == '0) ? FadeW'(1) : fade_tenths;
  // Multiply by 100 as 64 + 32 + 4.
  assign den_next = (DenW'(fade_eff) << 6) + (DenW'(fade_eff) << 5) + (DenW'(fade_eff) << 2);

  assign rem_sh   = {rem, 1'b0};
  assign rem_diff = rem_sh - {1'b0, den};

  assign peak_raw  = product[LevelW+GainW-1:1];
  assign peak      = (peak_raw > (LevelW+GainW-1)'(FullScale)) ? FullScale
                                                              : peak_raw[IntensW-1:0];
  assign red       = sat ? FullScale : IntensW'(quot);
  assign decayed   = (held_level > red) ? (held_level - red) : '0;
  assign held_next = (decayed < peak) ? peak : decayed;

  assign status.div_last = (step_cnt == LastStep);
  assign status.out_full = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_max      <= '0;
      prev_timestamp <= '0;
      held_level     <= '0;
      out_valid      <= 1'b0;
      step_cnt       <= '0;
    end else begin
      if (cmd.accept) begin
        if (last_bin) begin
          peak_max       <= folded;
          frame_max      <= '0;
          dt             <= (timestamp_ms >= prev_timestamp) ?
                            (timestamp_ms - prev_timestamp) : '0;
          prev_timestamp <= timestamp_ms;
          den            <= den_next;
        end else begin
          frame_max <= folded;
        end
      end

      if (cmd.prep) begin
        product  <= peak_max * gain;
        // Elapsed time of at least the denominator saturates the reduction.
        sat      <= (dt >= TimeW'(den));
        rem      <= dt[DenW-1:0];
        quot     <= '0;
        step_cnt <= '0;
      end

      if (cmd.div_step) begin
        if (!rem_diff[DenW]) begin
          rem  <= rem_diff[DenW-1:0];
          quot <= {quot[QuotW-2:0], 1'b1};
        end else begin
          rem  <= rem_sh[DenW-1:0];
          quot <= {quot[QuotW-2:0], 1'b0};
        end
        step_cnt <= step_cnt + StepCntW'(1);
      end

      if (cmd.finish) begin
        held_level <= held_next;
        intensity  <= held_next;
        out_valid  <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/spectrum_peak_hold_decay.sv @@
// Peak hold with linear decay over spectrum frames: configuration registers,
// controller and datapath. Depends on spd_pkg, spd_ctrl and spd_dpath.
// Ordinary bins are taken one per cycle while the block is idle. A last bin
// stalls the input through the multiply, the divider steps and the update; its
// result is valid when the update loads it, later if the output is still stalled.
// Synchronous reset clears the frame maximum, timestamp and held level, and
// sets gain to 1.0 and fade time to 1 s.
module spectrum_peak_hold_decay (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [spd_pkg::LevelW-1:0]    level,
  input  logic [spd_pkg::TimeW-1:0]     timestamp_ms,
  input  logic                          last_bin,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [spd_pkg::IntensW-1:0]   intensity
);
  import spd_pkg::*;

  logic [GainW-1:0] gain;
  logic [FadeW-1:0] fade_tenths;
  spd_cmd_t         cmd;
  spd_status_t      status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain        <= GainW'(256);
      fade_tenths <= FadeW'(10);
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == AddrFade[2]) fade_tenths <= pwdata[FadeW-1:0];
      else                         gain        <= pwdata[GainW-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == AddrGain[2]) prdata = 32'(gain);
    else                         prdata = 32'(fade_tenths);
  end

  spd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .last_bin (last_bin),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  spd_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .level        (level),
    .timestamp_ms (timestamp_ms),
    .last_bin     (last_bin),
    .gain         (gain),
    .fade_tenths  (fade_tenths),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .intensity    (intensity)
  );

endmodule

@@ test/tb_spectrum_peak_hold_decay.sv @@
// Self-checking testbench for spectrum_peak_hold_decay: directed table, then random frames.
// Predicts the held intensity per frame and checks it against the output channel.
// Depends on spd_pkg and the spectrum_peak_hold_decay RTL only.
module tb_spectrum_peak_hold_decay;
  timeunit 1ns;
  timeprecision 1ps;

  import spd_pkg::*;

  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned PhaseItems = 110;
  localparam int unsigned NumPhases = 11;
  localparam int unsigned NumDirRows = 26;
  localparam logic [31:0] FullQ15 = 32'(FullScale);

  typedef enum logic [1:0] {
    ROW_BIN,
    ROW_GAIN,
    ROW_FADE
  } row_kind_e;

  // want is only meaningful where typed is set.
  typedef struct packed {
    row_kind_e            kind;
    logic [15:0]          value;
    logic [TimeW-1:0]     ts;
    logic                 last;
    logic                 typed;
    logic [IntensW-1:0]   want;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [2:0]           paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [LevelW-1:0]    level = '0;
  logic [TimeW-1:0]     timestamp_ms = '0;
  logic                 last_bin = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [IntensW-1:0]   intensity;

  // Predicted block state and register shadows.
  logic [LevelW-1:0]    pk_max = '0;
  logic [TimeW-1:0]     pk_prev_ms = '0;
  logic [IntensW-1:0]   pk_held = '0;
  logic [GainW-1:0]     reg_gain = 16'd256;
  logic [FadeW-1:0]     reg_fade = 10'd10;

  logic [IntensW-1:0]   intens_due[$];
  logic [IntensW-1:0]   intens_want;
  dir_row_t             dir_rows [0:NumDirRows-1];

  int unsigned n_errors = 0;
  int unsigned n_bins = 0;
  int unsigned n_frames = 0;
  int unsigned n_writes = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet = 0;
  int unsigned hold_left = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_seen = 0;

  spectrum_peak_hold_decay i_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .level        (level),
    .timestamp_ms (timestamp_ms),
    .last_bin     (last_bin),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .intensity    (intensity)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Folds one bin into the predicted state; returns 1 when the bin closes a frame.
  function automatic logic fold_bin(input logic [LevelW-1:0] lvl, input logic [TimeW-1:0] ts,
                                    input logic last, output logic [IntensW-1:0] held_out);
    logic [31:0] peak;
    logic [31:0] dt;
    logic [63:0] den;
    logic [63:0] drop;
    held_out = '0;
    if (lvl > pk_max) pk_max = lvl;
    if (!last) return 1'b0;
    peak = (32'(pk_max) * 32'(reg_gain)) >> 1;
    if (peak > FullQ15) peak = FullQ15;
    dt = (ts >= pk_prev_ms) ? ts - pk_prev_ms : 32'd0;
    pk_prev_ms = ts;
    den = 64'd100 * ((reg_fade == '0) ? 64'd1 : 64'(reg_fade));
    drop = (64'(dt) * 64'(FullQ15)) / den;
    if (drop > 64'(FullQ15)) drop = 64'(FullQ15);
    pk_held = (64'(pk_held) > drop) ? pk_held - drop[IntensW-1:0] : '0;
    if (32'(pk_held) < peak) pk_held = peak[IntensW-1:0];
    pk_max = '0;
    held_out = pk_held;
    return 1'b1;
  endfunction

  // Offers one bin, waits for it to be taken and records the frame result it causes.
  task automatic offer_bin(input logic [LevelW-1:0] lvl, input logic [TimeW-1:0] ts,
                           input logic last, input logic typed, input logic [IntensW-1:0] want);
    logic [IntensW-1:0] held;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    level <= lvl;
    timestamp_ms <= ts;
    last_bin <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_bins++;
    if (fold_bin(lvl, ts, last, held)) begin
      intens_due.push_back(typed ? want : held);
      n_frames++;
    end
  endtask

  // Registers change only with the block drained and settled.
  task automatic set_register(input logic [2:0] addr, input logic [31:0] data);
    logic [31:0] readback;
    in_valid <= 1'b0;
    @(posedge clk);
    while (intens_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (addr == AddrGain) reg_gain = data[GainW-1:0];
    else if (addr == AddrFade) reg_fade = data[FadeW-1:0];
    n_writes++;
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (readback !== ((addr == AddrGain) ? 32'(reg_gain) : 32'(reg_fade))) begin
      $display("%0t ns: register at %0d read back expected %0d, actual %0d", $time, addr,
               (addr == AddrGain) ? 32'(reg_gain) : 32'(reg_fade), readback);
      n_errors++;
    end
  endtask

  // Frames are mostly short; levels lean towards the range where the peak is not clamped.
  task automatic send_random_frame();
    int unsigned len;
    int unsigned span;
    int unsigned roll;
    logic [LevelW-1:0] lvl;
    logic [TimeW-1:0] ts;
    len = ($urandom_range(99) < 90) ? $urandom_range(1, 12) : $urandom_range(13, 64);
    span = 100 * ((reg_fade == '0) ? 1 : int'(reg_fade));
    for (int unsigned i = 1; i <= len; i++) begin
      roll = $urandom_range(99);
      if (roll < 60) lvl = LevelW'($urandom_range(0, 300));
      else if (roll < 85) lvl = LevelW'($urandom);
      else lvl = '0;
      if (i < len) begin
        offer_bin(lvl, $urandom, 1'b0, 1'b0, '0);
      end else begin
        roll = $urandom_range(99);
        if (roll < 45) ts = pk_prev_ms + $urandom_range(0, span / 4);
        else if (roll < 65) ts = pk_prev_ms + $urandom_range(0, 20);
        else if (roll < 75) ts = pk_prev_ms + $urandom_range(span, 2 * span);
        else if (roll < 85) ts = pk_prev_ms - $urandom_range(1, 5000);
        else ts = $urandom;
        offer_bin(lvl, ts, 1'b1, 1'b0, '0);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (intens_due.size() == 0) begin
          $display("%0t ns: intensity with none expected, expected none, actual %0d",
                   $time, intensity);
          n_errors++;
        end else begin
          intens_want = intens_due.pop_front();
          if (intensity !== intens_want) begin
            $display("%0t ns: intensity expected %0d, actual %0d", $time, intens_want,
                     intensity);
            n_errors++;
          end
        end
      end
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        hold_left = HoldCycles;
      end
    end
    if (hold_left != 0) hold_left--;
    out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QuietLimit) begin
      $display("%0t ns: no item moved for %0d cycles", $time, quiet);
      $display("spectrum_peak_hold_decay verification failed");
      $finish;
    end
  end

  initial begin
    dir_rows = '{
      '{ROW_BIN,  16'd0,     32'd0,          1'b1, 1'b1, 16'd0},
      '{ROW_BIN,  16'hFFFF,  32'hFFFF_FFFF,  1'b0, 1'b0, 16'd0},
      '{ROW_BIN,  16'd0,     32'h5555_AAAA,  1'b0, 1'b0, 16'd0},
      '{ROW_BIN,  16'd5,     32'd100,        1'b1, 1'b1, 16'd32768},
      '{ROW_BIN,  16'd0,     32'd200,        1'b1, 1'b1, 16'd29492},
      '{ROW_BIN,  16'd0,     32'd150,        1'b1, 1'b1, 16'd29492},
      '{ROW_BIN,  16'd0,     32'd1150,       1'b1, 1'b1, 16'd0},
      '{ROW_BIN,  16'd128,   32'd1150,       1'b1, 1'b1, 16'd16384},
      '{ROW_BIN,  16'd200,   32'hAAAA_5555,  1'b0, 1'b0, 16'd0},
      '{ROW_BIN,  16'd100,   32'd1160,       1'b1, 1'b0, 16'd0},
      '{ROW_GAIN, 16'd0,     32'd0,          1'b0, 1'b0, 16'd0},
      '{ROW_BIN,  16'hFFFF,  32'd1260,       1'b1, 1'b0, 16'd0},
      '{ROW_GAIN, 16'hFFFF,  32'd0,          1'b0, 1'b0, 16'd0},
      '{ROW_BIN,  16'd1,     32'd1260,       1'b1, 1'b0, 16'd0},
      '{ROW_FADE, 16'd0,     32'd0,          1'b0, 1'b0, 16'd0},
      '{ROW_BIN,  16'd0,     32'd1261,       1'b1, 1'b0, 16'd0},
      '{ROW_BIN,  16'd0,     32'd1361,       1'b1, 1'b1, 16'd0},
      '{ROW_FADE, 16'd1000,  32'd0,          1'b0, 1'b0, 16'd0},
      '{ROW_BIN,  16'd2,     32'd1361,       1'b1, 1'b1, 16'd32768},
      '{ROW_BIN,  16'd0,     32'hFFFF_FFFF,  1'b1, 1'b1, 16'd0},
      '{ROW_BIN,  16'd0,     32'd0,          1'b1, 1'b1, 16'd0},
      '{ROW_FADE, 16'd1,     32'd0,          1'b0, 1'b0, 16'd0},
      '{ROW_GAIN, 16'd256,   32'd0,          1'b0, 1'b0, 16'd0},
      '{ROW_BIN,  16'd256,   32'd50,         1'b1, 1'b1, 16'd32768},
      '{ROW_BIN,  16'd0,     32'd51,         1'b1, 1'b0, 16'd0},
      '{ROW_FADE, 16'd10,    32'd0,          1'b0, 1'b0, 16'd0}
    };
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    gap_pct = 6;
    stall_pct = 6;
    foreach (dir_rows[r]) begin
      case (dir_rows[r].kind)
        ROW_GAIN: set_register(AddrGain, 32'(dir_rows[r].value));
        ROW_FADE: set_register(AddrFade, 32'(dir_rows[r].value[FadeW-1:0]));
        default:  offer_bin(dir_rows[r].value, dir_rows[r].ts, dir_rows[r].last,
                            dir_rows[r].typed, dir_rows[r].want);
      endcase
    end

    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      int unsigned start_bins;
      int unsigned roll;
      logic [GainW-1:0] new_gain;
      logic [FadeW-1:0] new_fade;
      roll = $urandom_range(99);
      if (roll < 30) new_gain = 16'd256;
      else if (roll < 40) new_gain = '0;
      else if (roll < 50) new_gain = 16'hFFFF;
      else if (roll < 80) new_gain = GainW'($urandom_range(0, 1023));
      else new_gain = GainW'($urandom);
      roll = $urandom_range(99);
      if (roll < 15) new_fade = 10'd1;
      else if (roll < 30) new_fade = 10'd1000;
      else if (roll < 40) new_fade = '0;
      else if (roll < 55) new_fade = 10'd10;
      else new_fade = FadeW'($urandom_range(1, 1000));
      set_register(AddrGain, 32'(new_gain));
      set_register(AddrFade, 32'(new_fade));
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 84; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 84; end
        default: begin gap_pct = 6; stall_pct = 6; end
      endcase
      // A long hold on the output while bins keep coming fills the block up.
      if (ph == 4) hold_asked++;
      start_bins = n_bins;
      while (n_bins - start_bins < PhaseItems) send_random_frame();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (intens_due.size() != 0) @(posedge clk);
    repeat (2 * SettleCycles) @(posedge clk);
    $display("Covered %0d bins in %0d frames and %0d register writes,", n_bins, n_frames,
             n_writes);
    $display("through free-running, sender-idle, receiver-stall and held-output phases.");
    if (n_errors == 0) begin
      $display("spectrum_peak_hold_decay verification clean");
    end else begin
      $display("spectrum_peak_hold_decay verification failed");
    end
    $finish;
  end

endmodule
